>>> rtl/invcnt_pkg.sv
`default_nettype none

package invcnt_pkg;

  localparam int DATA_W      = 32;
  localparam int TOTAL_W     = 15;
  localparam int MAX_LEN_DEF = 256;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // control carried by a transaction as it moves along the chain
  typedef struct packed {
    logic valid;
    logic last;
    logic skip;    // arrived past capacity: no compare, no store
    logic placed;  // already stored in an earlier cell
  } tok_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/invcnt_if.sv
`default_nettype none

interface invcnt_in_if;
  logic                             valid;
  logic                             ready;
  logic [invcnt_pkg::DATA_W-1:0]    element_value;
  logic                             last_element;

  modport source (output valid, output element_value, output last_element, input ready);
  modport sink   (input valid, input element_value, input last_element, output ready);
endinterface

interface invcnt_out_if;
  logic                             valid;
  logic                             ready;
  logic [invcnt_pkg::TOTAL_W-1:0]   inversion_count;
  logic                             length_overflow;

  modport source (output valid, output inversion_count, output length_overflow, input ready);
  modport sink   (input valid, input inversion_count, input length_overflow, output ready);
endinterface

`default_nettype wire

>>> rtl/invcnt_cell.sv
`default_nettype none

module invcnt_cell #(
  parameter int CNT_W = 8
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 en,
  input  wire  invcnt_pkg::tok_ctrl_t         tok_in,
  input  wire  [invcnt_pkg::DATA_W-1:0]       val_in,
  input  wire  [CNT_W-1:0]                    cnt_in,
  output invcnt_pkg::tok_ctrl_t               tok_out,
  output logic [invcnt_pkg::DATA_W-1:0]       val_out,
  output logic [CNT_W-1:0]                    cnt_out,
  output logic                                occ
);

  invcnt_pkg::tok_ctrl_t             tok_r, tok_nxt;
  logic [invcnt_pkg::DATA_W-1:0]     val_r;
  logic [CNT_W-1:0]                  cnt_r, cnt_nxt;
  logic [invcnt_pkg::DATA_W-1:0]     store_r;
  logic                              occ_r, occ_nxt;
  logic                              active, hit, place;

  always_comb begin
    active  = tok_in.valid && !tok_in.skip;
    hit     = active && occ_r && ($signed(store_r) > $signed(val_in));
    place   = active && !tok_in.last && !tok_in.placed && !occ_r;
    cnt_nxt = cnt_in + CNT_W'(hit);
    tok_nxt = tok_in;
    tok_nxt.placed = tok_in.placed | place;
    if (tok_in.valid && tok_in.last) begin
      occ_nxt = 1'b0;
    end else if (place) begin
      occ_nxt = 1'b1;
    end else begin
      occ_nxt = occ_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
      occ_r <= 1'b0;
    end else if (en) begin
      tok_r <= tok_nxt;
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val_r <= val_in;
      cnt_r <= cnt_nxt;
      if (place) begin
        store_r <= val_in;
      end
    end
  end

  assign tok_out = tok_r;
  assign val_out = val_r;
  assign cnt_out = cnt_r;
  assign occ     = occ_r;

endmodule

`default_nettype wire

>>> rtl/inversion_counter_top.sv
// A sequence's result is registered in the output register once its last element leaves the chain.
// Throughput: one element per cycle unless stalled; each transaction walks
// the cell chain, one cell per cycle, comparing against the value held there.
// Output register stalls the whole chain while a result waits.
// Reset (rst_n, synchronous, active low) empties the chain and clears counters;
// stored element values are not reset.
`default_nettype none

module inversion_counter_top #(
  parameter int MAX_LEN = invcnt_pkg::MAX_LEN_DEF
) (
  input  wire           clk,
  input  wire           rst_n,
  invcnt_in_if.sink     in_ch,
  invcnt_out_if.source  out_ch
);

  localparam int CNT_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CAP_W = $clog2(MAX_LEN + 1);
  localparam int SUM_W = invcnt_pkg::TOTAL_W + 1;

  invcnt_pkg::tok_ctrl_t             tok_chain [0:MAX_LEN];
  logic [invcnt_pkg::DATA_W-1:0]     val_chain [0:MAX_LEN];
  logic [CNT_W-1:0]                  cnt_chain [0:MAX_LEN];
  logic [MAX_LEN-1:0]                cell_occ;

  logic                              en;
  logic                              accept;
  logic                              skip;
  logic [CAP_W-1:0]                  count_r, count_nxt;
  logic [invcnt_pkg::TOTAL_W-1:0]    total_r, total_nxt, total_sat;
  logic                              ovf_r, ovf_nxt, ovf_seq;
  logic [SUM_W-1:0]                  sum;
  logic                              out_valid_r, out_valid_nxt;
  logic [invcnt_pkg::TOTAL_W-1:0]    out_count_r;
  logic                              out_ovf_r;
  invcnt_pkg::tok_ctrl_t             exit_tok;

  assign en           = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = en;
  assign accept       = in_ch.valid && en;
  assign skip         = (count_r == CAP_W'(MAX_LEN));

  // valid, last, skip, placed
  assign tok_chain[0] = {in_ch.valid, in_ch.last_element, skip, 1'b0};
  assign val_chain[0] = in_ch.element_value;
  assign cnt_chain[0] = '0;

  for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
    invcnt_cell #(.CNT_W(CNT_W)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .tok_in  (tok_chain[g]),
      .val_in  (val_chain[g]),
      .cnt_in  (cnt_chain[g]),
      .tok_out (tok_chain[g+1]),
      .val_out (val_chain[g+1]),
      .cnt_out (cnt_chain[g+1]),
      .occ     (cell_occ[g])
    );
  end

  assign exit_tok = tok_chain[MAX_LEN];

  always_comb begin
    if (!accept) begin
      count_nxt = count_r;
    end else if (in_ch.last_element) begin
      count_nxt = '0;
    end else if (skip) begin
      count_nxt = count_r;
    end else begin
      count_nxt = count_r + CAP_W'(1);
    end
  end

  always_comb begin
    sum       = {1'b0, total_r} + SUM_W'(cnt_chain[MAX_LEN]);
    total_sat = sum[SUM_W-1] ? invcnt_pkg::TOTAL_MAX : sum[SUM_W-2:0];
    ovf_seq   = ovf_r | exit_tok.skip;
    total_nxt = total_r;
    ovf_nxt   = ovf_r;
    if (en && exit_tok.valid) begin
      if (exit_tok.last) begin
        total_nxt = '0;
        ovf_nxt   = 1'b0;
      end else begin
        total_nxt = total_sat;
        ovf_nxt   = ovf_seq;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (en) begin
      out_valid_nxt = exit_tok.valid && exit_tok.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      total_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en && exit_tok.valid && exit_tok.last) begin
      out_count_r <= total_sat;
      out_ovf_r   <= ovf_seq;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.inversion_count = out_count_r;
  assign out_ch.length_overflow = out_ovf_r;

`ifndef ASSERT_OFF
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_W'(MAX_LEN))
    else $error("stored count beyond capacity");

  a_first_cell: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> !cell_occ[0])
    else $error("first cell occupied with empty sequence");

  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    (en && exit_tok.valid && exit_tok.last) |=> out_ch.valid)
    else $error("last transaction left chain without a result");
`endif

endmodule

`default_nettype wire
